>>> rtl/soa_pkg.sv
`default_nettype none

package soa_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 32;

  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 2;
  localparam int DIST_W   = 12;
  localparam int WHEEL_W  = 32;
  localparam int DRIVE_W  = 3;
  localparam int COUNTS_W = 16;
  localparam int TICK_W   = 10;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef logic [DRIVE_W-1:0] drive_code_t;
  typedef logic [MODE_W-1:0]  item_mode_t;

  localparam item_mode_t MODE_TICK   = 2'd0;
  localparam item_mode_t MODE_SONAR  = 2'd1;
  localparam item_mode_t MODE_WHEEL  = 2'd2;
  localparam item_mode_t MODE_ENABLE = 2'd3;

  localparam drive_code_t DRV_FWD   = 3'd0;
  localparam drive_code_t DRV_BACK  = 3'd1;
  localparam drive_code_t DRV_LEFT  = 3'd2;
  localparam drive_code_t DRV_RIGHT = 3'd3;
  localparam drive_code_t DRV_STOP  = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_SAFE_DIST  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_DIST = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REVERSE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WARMUP     = 3'd4;

  localparam logic [DIST_W-1:0]   SAFE_DIST_RST  = 12'd27;
  localparam logic [DIST_W-1:0]   CLEAR_DIST_RST = 12'd30;
  localparam logic [COUNTS_W-1:0] REVERSE_RST    = 16'd500;
  localparam logic [COUNTS_W-1:0] TURN_RST       = 16'd500;
  localparam logic [TICK_W-1:0]   WARMUP_RST     = 10'd55;

  localparam logic [TICK_W-1:0]   TICK_MAX = '1;

endpackage

`default_nettype wire

>>> rtl/soa_item_if.sv
`default_nettype none

interface soa_item_if
  import soa_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [INDEX_W-1:0]   sensor_index;
  logic [DIST_W-1:0]    distance_cm;
  logic [WHEEL_W-1:0]   wheel_count;
  logic                 enable;

  modport source (
    output valid, mode, sensor_index, distance_cm, wheel_count, enable,
    input  ready
  );
  modport sink (
    input  valid, mode, sensor_index, distance_cm, wheel_count, enable,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/soa_result_if.sv
`default_nettype none

interface soa_result_if
  import soa_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] drive_code;

  modport source (
    output valid, drive_code,
    input  ready
  );
  modport sink (
    input  valid, drive_code,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/sonar_obstacle_avoid_fsm.sv
// Channel   Dir  Handshake     Payload
// item      in   valid/ready   mode, sensor_index, distance_cm, wheel_count, enable
// result    out  valid/ready   drive_code
// cfg       in   cfg_wr_en     cfg_index, cfg_data (no read-back)
//
// One beat per cycle while the result register is not held full; a beat is
// registered in the input stage, then decoded and applied to the state, and a
// tick's drive code is registered into the result register as the state updates. The input stage holds only while
// the result register is full and not taken. Reset (synchronous) clears sensor
// flags, modes and the tick count and loads the register defaults.
`default_nettype none

module sonar_obstacle_avoid_fsm
  import soa_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  soa_item_if.sink                    item,
  soa_result_if.source                result,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [COUNT_WIDTH-1:0] MARK_RST = COUNT_WIDTH'(1);

  // configuration
  logic [DIST_W-1:0]   safe_dist;
  logic [DIST_W-1:0]   clear_dist;
  logic [COUNTS_W-1:0] reverse_counts;
  logic [COUNTS_W-1:0] turn_counts;
  logic [TICK_W-1:0]   warmup_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      safe_dist      <= SAFE_DIST_RST;
      clear_dist     <= CLEAR_DIST_RST;
      reverse_counts <= REVERSE_RST;
      turn_counts    <= TURN_RST;
      warmup_ticks   <= WARMUP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SAFE_DIST:  safe_dist      <= cfg_data[DIST_W-1:0];
        REG_CLEAR_DIST: clear_dist     <= cfg_data[DIST_W-1:0];
        REG_REVERSE:    reverse_counts <= cfg_data;
        REG_TURN:       turn_counts    <= cfg_data;
        REG_WARMUP:     warmup_ticks   <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic                   s1_valid;
  item_mode_t             s1_mode;
  logic [INDEX_W-1:0]     s1_index;
  logic [DIST_W-1:0]      s1_dist;
  logic [COUNT_WIDTH-1:0] s1_count;
  logic                   s1_enable;
  logic                   s1_adv;
  logic                   s1_fire;
  logic [63:0]            wheel_wide;

  assign s1_adv     = !result.valid || result.ready;
  assign s1_fire    = s1_valid && s1_adv;
  assign item.ready = !s1_valid || s1_adv;
  assign wheel_wide = {32'd0, item.wheel_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      s1_mode   <= item.mode;
      s1_index  <= item.sensor_index;
      s1_dist   <= item.distance_cm;
      s1_count  <= wheel_wide[COUNT_WIDTH-1:0];
      s1_enable <= item.enable;
    end
  end

  // controller state
  logic [DIST_W-1:0]      sonar_value [3];
  logic [2:0]             sonar_fresh;
  logic [COUNT_WIDTH-1:0] wheel_value [2];
  logic [1:0]             wheel_fresh;
  logic [COUNT_WIDTH-1:0] wheel_mark  [2];
  drive_code_t            drive_state;
  drive_code_t            prior_state;
  logic [TICK_W-1:0]      tick_counter;
  logic                   enable_flag;

  logic [DIST_W-1:0]      sonar_value_next [3];
  logic [2:0]             sonar_fresh_next;
  logic [COUNT_WIDTH-1:0] wheel_value_next [2];
  logic [1:0]             wheel_fresh_next;
  logic [COUNT_WIDTH-1:0] wheel_mark_next  [2];
  drive_code_t            drive_state_next;
  drive_code_t            prior_state_next;
  logic [TICK_W-1:0]      tick_counter_next;
  logic                   enable_flag_next;
  logic                   emit;

  logic                   all_fresh;
  logic                   close0, close1, clear0, clear1, clear2;
  logic [COUNT_WIDTH-1:0] adv0, adv1;
  logic                   adv1_rev, adv1_turn, adv0_turn;
  logic                   stalled;
  drive_code_t            ds0;
  drive_code_t            decided;
  logic                   take_marks;

  assign all_fresh = (&sonar_fresh) && (&wheel_fresh);
  assign close0 = (sonar_value[0] != '0) && (sonar_value[0] < safe_dist);
  assign close1 = (sonar_value[1] != '0) && (sonar_value[1] < safe_dist);
  assign clear0 = (sonar_value[0] == '0) || (sonar_value[0] > clear_dist);
  assign clear1 = (sonar_value[1] == '0) || (sonar_value[1] > clear_dist);
  assign clear2 = (sonar_value[2] == '0) || (sonar_value[2] > clear_dist);
  assign adv0 = wheel_value[0] - wheel_mark[0];
  assign adv1 = wheel_value[1] - wheel_mark[1];
  assign adv1_rev  = adv1 > COUNT_WIDTH'(reverse_counts);
  assign adv1_turn = adv1 > COUNT_WIDTH'(turn_counts);
  assign adv0_turn = adv0 > COUNT_WIDTH'(turn_counts);
  assign stalled = (prior_state == DRV_FWD) &&
                   ((wheel_mark[0] == wheel_value[0]) || (wheel_mark[1] == wheel_value[1]));
  assign ds0 = (drive_state == DRV_STOP) ? DRV_FWD : drive_state;

  always_comb begin
    decided    = ds0;
    take_marks = 1'b0;
    unique case (ds0)
      DRV_FWD: begin
        take_marks = 1'b1;
        if (close0 || close1 || stalled) decided = DRV_BACK;
      end
      DRV_BACK: begin
        if (clear0 && clear1 && adv1_rev) begin
          decided    = clear2 ? DRV_LEFT : DRV_RIGHT;
          take_marks = 1'b1;
        end
      end
      DRV_LEFT: begin
        if (adv1_turn) decided = DRV_FWD;
      end
      DRV_RIGHT: begin
        if (adv0_turn) decided = DRV_FWD;
      end
      default: ;
    endcase
  end

  always_comb begin
    sonar_value_next  = sonar_value;
    sonar_fresh_next  = sonar_fresh;
    wheel_value_next  = wheel_value;
    wheel_fresh_next  = wheel_fresh;
    wheel_mark_next   = wheel_mark;
    drive_state_next  = drive_state;
    prior_state_next  = prior_state;
    tick_counter_next = tick_counter;
    enable_flag_next  = enable_flag;
    emit              = 1'b0;
    if (s1_fire) begin
      unique case (s1_mode)
        MODE_SONAR: begin
          for (int i = 0; i < 3; i++) begin
            if (s1_index == INDEX_W'(i)) begin
              sonar_value_next[i] = s1_dist;
              sonar_fresh_next[i] = 1'b1;
            end
          end
        end
        MODE_WHEEL: begin
          for (int i = 0; i < 2; i++) begin
            if (s1_index == INDEX_W'(i)) begin
              wheel_value_next[i] = s1_count;
              wheel_fresh_next[i] = 1'b1;
            end
          end
        end
        MODE_ENABLE: begin
          enable_flag_next = s1_enable;
        end
        MODE_TICK: begin
          if (tick_counter != TICK_MAX) tick_counter_next = tick_counter + 1'b1;
          if (all_fresh) begin
            sonar_fresh_next = '0;
            wheel_fresh_next = '0;
            if (tick_counter_next >= warmup_ticks) begin
              drive_state_next = decided;
              if (take_marks) wheel_mark_next = wheel_value;
            end else begin
              drive_state_next = DRV_STOP;
            end
            emit = enable_flag;
          end
          prior_state_next = drive_state_next;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sonar_value  <= '{default: '0};
      sonar_fresh  <= '0;
      wheel_value  <= '{default: '0};
      wheel_fresh  <= '0;
      wheel_mark   <= '{default: MARK_RST};
      drive_state  <= DRV_STOP;
      prior_state  <= DRV_STOP;
      tick_counter <= '0;
      enable_flag  <= 1'b0;
    end else begin
      sonar_value  <= sonar_value_next;
      sonar_fresh  <= sonar_fresh_next;
      wheel_value  <= wheel_value_next;
      wheel_fresh  <= wheel_fresh_next;
      wheel_mark   <= wheel_mark_next;
      drive_state  <= drive_state_next;
      prior_state  <= prior_state_next;
      tick_counter <= tick_counter_next;
      enable_flag  <= enable_flag_next;
    end
  end

  // result register
  logic        res_valid;
  drive_code_t res_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= emit;
    end
    if (s1_adv && emit) begin
      res_code <= drive_state_next;
    end
  end

  assign result.valid      = res_valid;
  assign result.drive_code = res_code;

  // checks
  a_fresh_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_mode == MODE_TICK && all_fresh) |=> (sonar_fresh == '0 && wheel_fresh == '0))
    else $error("freshness flags not cleared after a step");

  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(s1_fire && s1_mode == MODE_TICK && enable_flag))
    else $error("result without an enabled tick");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.drive_code <= DRV_STOP))
    else $error("drive code out of range");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_mode) && $stable(s1_index)))
    else $error("input stage lost a held beat");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import soa_pkg::*;

  localparam int LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    item_mode_t           mode;
    logic [INDEX_W-1:0]   idx;
    logic [DIST_W-1:0]    dist_cm;
    logic [WHEEL_W-1:0]   count;
    logic                 en;
    bit                   has_exp;
    drive_code_t          exp;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  soa_item_if   item_ch();
  soa_result_if result_ch();

  sonar_obstacle_avoid_fsm dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // navigation model state
  logic [DIST_W-1:0]   lim_safe, lim_clear;
  logic [COUNTS_W-1:0] lim_rev, lim_turn;
  logic [TICK_W-1:0]   lim_warm;
  logic [DIST_W-1:0]   seen_dist[3];
  bit                  dist_new[3];
  logic [WHEEL_W-1:0]  seen_count[2];
  bit                  count_new[2];
  logic [WHEEL_W-1:0]  count_ref[2];
  drive_code_t         nav_mode, nav_prev;
  logic [TICK_W-1:0]   tick_cnt;
  bit                  out_en;

  drive_code_t  drive_due[$];
  beat_t        on_bus;
  beat_t        dir_rows[$];
  logic [WHEEL_W-1:0] odo[2] = '{32'd0, 32'd0};
  int  errors = 0;
  int  cycles = 0;
  int  beats_sent = 0;
  bit  tx_quiet = 1'b0;
  bit  rx_quiet = 1'b0;
  bit  hold_req = 1'b0;

  function automatic void reset_model();
    lim_safe  = SAFE_DIST_RST;
    lim_clear = CLEAR_DIST_RST;
    lim_rev   = REVERSE_RST;
    lim_turn  = TURN_RST;
    lim_warm  = WARMUP_RST;
    foreach (seen_dist[i]) begin
      seen_dist[i] = '0;
      dist_new[i] = 1'b0;
    end
    foreach (seen_count[i]) begin
      seen_count[i] = '0;
      count_new[i] = 1'b0;
      count_ref[i] = 32'd1;
    end
    nav_mode = DRV_STOP;
    nav_prev = DRV_STOP;
    tick_cnt = '0;
    out_en = 1'b0;
  endfunction

  function automatic bit is_near(logic [DIST_W-1:0] d);
    return d != 0 && d < lim_safe;
  endfunction

  function automatic bit is_open(logic [DIST_W-1:0] d);
    return d == 0 || d > lim_clear;
  endfunction

  function automatic void nav_step(input beat_t b, output bit fired, output drive_code_t code);
    logic [WHEEL_W-1:0] adv0, adv1;
    fired = 1'b0;
    code = DRV_STOP;
    case (b.mode)
      MODE_SONAR: begin
        if (b.idx < 3) begin
          seen_dist[b.idx] = b.dist_cm;
          dist_new[b.idx] = 1'b1;
        end
      end
      MODE_WHEEL: begin
        if (b.idx < 2) begin
          seen_count[b.idx[0]] = b.count;
          count_new[b.idx[0]] = 1'b1;
        end
      end
      MODE_ENABLE: out_en = b.en;
      default: begin
        if (tick_cnt != TICK_MAX) tick_cnt++;
        if (dist_new[0] && dist_new[1] && dist_new[2] && count_new[0] && count_new[1]) begin
          foreach (dist_new[i]) dist_new[i] = 1'b0;
          foreach (count_new[i]) count_new[i] = 1'b0;
          if (tick_cnt >= lim_warm) begin
            if (nav_mode == DRV_STOP) nav_mode = DRV_FWD;
            adv0 = seen_count[0] - count_ref[0];
            adv1 = seen_count[1] - count_ref[1];
            case (nav_mode)
              DRV_FWD: begin
                if (is_near(seen_dist[1]) || is_near(seen_dist[0])) nav_mode = DRV_BACK;
                for (int w = 0; w < 2; w++) begin
                  if (count_ref[w] == seen_count[w] && nav_prev == DRV_FWD) nav_mode = DRV_BACK;
                  count_ref[w] = seen_count[w];
                end
              end
              DRV_BACK: begin
                if (is_open(seen_dist[1]) && is_open(seen_dist[0]) && adv1 > lim_rev) begin
                  nav_mode = is_open(seen_dist[2]) ? DRV_LEFT : DRV_RIGHT;
                  count_ref = seen_count;
                end
              end
              DRV_LEFT: if (adv1 > lim_turn) nav_mode = DRV_FWD;
              DRV_RIGHT: if (adv0 > lim_turn) nav_mode = DRV_FWD;
              default: ;
            endcase
          end else begin
            nav_mode = DRV_STOP;
          end
          if (out_en) begin
            fired = 1'b1;
            code = nav_mode;
          end
        end
        nav_prev = nav_mode;
      end
    endcase
  endfunction

  function automatic beat_t mk(item_mode_t m, int idx, int dist_cm, logic [WHEEL_W-1:0] count,
                               bit en);
    beat_t b;
    b.mode = m;
    b.idx = idx[INDEX_W-1:0];
    b.dist_cm = dist_cm[DIST_W-1:0];
    b.count = count;
    b.en = en;
    b.has_exp = 1'b0;
    b.exp = DRV_STOP;
    return b;
  endfunction

  function automatic beat_t gives(drive_code_t c);
    beat_t b;
    b = mk(MODE_TICK, 0, 0, '0, 1'b0);
    b.has_exp = 1'b1;
    b.exp = c;
    return b;
  endfunction

  function automatic beat_t noise_beat();
    return mk(item_mode_t'($urandom_range(0, 3)), $urandom_range(0, 3), $urandom_range(0, 4095),
              $urandom, $urandom_range(0, 1));
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [DIST_W-1:0] pick_dist();
    int r, v;
    r = $urandom_range(0, 19);
    if (r < 3) v = 0;
    else if (r < 5) v = (lim_safe > 1) ? $urandom_range(1, lim_safe - 1) : 1;
    else if (r == 5) v = 4095;
    else if (r == 6) v = $urandom_range(0, 4095);
    else if (r < 9) v = ((r == 7) ? int'(lim_safe) : int'(lim_clear)) + $urandom_range(0, 2) - 1;
    else v = (lim_clear < 4095) ? $urandom_range(lim_clear + 1, 4095) : 0;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[DIST_W-1:0];
  endfunction

  function automatic logic [WHEEL_W-1:0] wheel_step();
    int lim, r;
    lim = (lim_rev > lim_turn) ? int'(lim_rev) : int'(lim_turn);
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return $urandom;
    if (r < 7) return $urandom_range(1, lim / 4 + 1);
    return $urandom_range(lim / 2 + 1, lim + 300);
  endfunction

  task automatic send_beat(beat_t b);
    int gap;
    gap = pick_gap(tx_quiet);
    repeat (gap) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
    end
    @(negedge clk);
    on_bus = b;
    item_ch.valid <= 1'b1;
    item_ch.mode <= b.mode;
    item_ch.sensor_index <= b.idx;
    item_ch.distance_cm <= b.dist_cm;
    item_ch.wheel_count <= b.count;
    item_ch.enable <= b.en;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_SAFE_DIST:  lim_safe = data[DIST_W-1:0];
      REG_CLEAR_DIST: lim_clear = data[DIST_W-1:0];
      REG_REVERSE:    lim_rev = data;
      REG_TURN:       lim_turn = data;
      REG_WARMUP:     lim_warm = data[TICK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic configure(int safe, int clear, int rev, int turn, int warm);
    write_reg(REG_SAFE_DIST, safe[CFG_DATA_W-1:0]);
    write_reg(REG_CLEAR_DIST, clear[CFG_DATA_W-1:0]);
    write_reg(REG_REVERSE, rev[CFG_DATA_W-1:0]);
    write_reg(REG_TURN, turn[CFG_DATA_W-1:0]);
    write_reg(REG_WARMUP, warm[CFG_DATA_W-1:0]);
  endtask

  // one decision's worth of readings, shuffled, sometimes broken, then a tick
  task automatic run_frame();
    beat_t f[$];
    beat_t t;
    int k;
    for (int w = 0; w < 2; w++) odo[w] += wheel_step();
    for (int s = 0; s < 3; s++) f.push_back(mk(MODE_SONAR, s, pick_dist(), '0, 1'b0));
    for (int w = 0; w < 2; w++) f.push_back(mk(MODE_WHEEL, w, 0, odo[w], 1'b0));
    if ($urandom_range(0, 9) == 0) f.delete($urandom_range(0, 4));
    if ($urandom_range(0, 7) == 0) f.push_back(noise_beat());
    for (int j = f.size() - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      t = f[j];
      f[j] = f[k];
      f[k] = t;
    end
    foreach (f[i]) send_beat(f[i]);
    if ($urandom_range(0, 11) == 0) send_beat(mk(MODE_ENABLE, 0, 0, '0, $urandom_range(0, 4) != 0));
    send_beat(mk(MODE_TICK, 0, 0, '0, 1'b0));
  endtask

  task automatic run_phase(int n);
    int start, frames;
    start = beats_sent;
    frames = 0;
    send_beat(mk(MODE_ENABLE, 0, 0, '0, 1'b1));
    while (beats_sent - start < n) begin
      if (frames % 10 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 6) == 0) send_beat(noise_beat());
      else run_frame();
      frames++;
      if (frames == 12) drain();
    end
    drain();
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t: timeout", $time);
      $display("sonar_obstacle_avoid_fsm test failed");
      $finish;
    end
  end

  always @(posedge clk) begin : watch
    drive_code_t want;
    bit fired;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        if (drive_due.size() == 0) begin
          $display("%0t: unexpected drive_code beat, expected none, got %0d", $time,
                   result_ch.drive_code);
          errors++;
        end else begin
          want = drive_due.pop_front();
          if (result_ch.drive_code !== want) begin
            $display("%0t: drive_code mismatch, expected %0d, got %0d", $time, want,
                     result_ch.drive_code);
            errors++;
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        nav_step(on_bus, fired, want);
        if (on_bus.has_exp) drive_due.push_back(on_bus.exp);
        else if (fired) drive_due.push_back(want);
      end
    end
  end

  initial begin : sink_side
    int low_left, hold_left;
    low_left = 0;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (low_left > 0) begin
        low_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        low_left = pick_gap(rx_quiet);
      end
    end
  end

  initial begin : stimulus
    item_ch.valid = 1'b0;
    item_ch.mode = MODE_TICK;
    item_ch.sensor_index = '0;
    item_ch.distance_cm = '0;
    item_ch.wheel_count = '0;
    item_ch.enable = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_SAFE_DIST;
    cfg_data = '0;
    reset_model();

    dir_rows = '{
      mk(MODE_ENABLE, 0, 0, '0, 1'b1),
      mk(MODE_SONAR, 0, 0, '0, 1'b0),
      mk(MODE_SONAR, 1, 4095, '0, 1'b0),
      mk(MODE_SONAR, 2, 1, '0, 1'b0),
      mk(MODE_WHEEL, 0, 0, 32'hFFFF_FFFF, 1'b0),
      mk(MODE_WHEEL, 1, 0, 32'h0, 1'b0),
      gives(DRV_STOP),
      mk(MODE_TICK, 0, 0, '0, 1'b0),
      mk(MODE_SONAR, 3, 4095, '0, 1'b0),
      mk(MODE_WHEEL, 2, 0, 32'h1234_5678, 1'b0),
      mk(MODE_WHEEL, 3, 0, 32'hFFFF_FFFF, 1'b0),
      mk(MODE_SONAR, 0, 200, '0, 1'b0),
      mk(MODE_SONAR, 1, 200, '0, 1'b0),
      mk(MODE_SONAR, 2, 0, '0, 1'b0),
      mk(MODE_WHEEL, 0, 0, 32'hFFFF_FFFF, 1'b0),
      mk(MODE_WHEEL, 1, 0, 32'h0, 1'b0),
      gives(DRV_FWD),
      // same counts again: both wheels stalled while going forward
      mk(MODE_SONAR, 0, 200, '0, 1'b0),
      mk(MODE_SONAR, 1, 200, '0, 1'b0),
      mk(MODE_SONAR, 2, 0, '0, 1'b0),
      mk(MODE_WHEEL, 0, 0, 32'hFFFF_FFFF, 1'b0),
      mk(MODE_WHEEL, 1, 0, 32'h0, 1'b0),
      mk(MODE_TICK, 0, 0, '0, 1'b0)
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(REG_WARMUP, 16'd2);
    foreach (dir_rows[i]) send_beat(dir_rows[i]);
    drain();

    configure($urandom_range(5, 60), $urandom_range(20, 120), $urandom_range(0, 1500),
              $urandom_range(0, 1500), $urandom_range(0, 40));
    hold_req = 1'b1;
    run_phase(180);

    configure(SAFE_DIST_RST, CLEAR_DIST_RST, REVERSE_RST, TURN_RST, WARMUP_RST);
    run_phase(180);

    configure(0, 0, 0, 0, 0);
    run_phase(180);

    // longest warm-up: held at stop for the whole phase
    configure(4095, 4095, 65535, 65535, 1023);
    run_phase(180);

    configure($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 1023));
    run_phase(180);

    drain();
    if (errors == 0) begin
      $display("sonar_obstacle_avoid_fsm test passed");
    end else begin
      $display("sonar_obstacle_avoid_fsm test failed");
    end
    $finish;
  end

endmodule
